>>> hdl/cafe_pkg.sv
// -----------------------------------------------------------------------------
// cafe_pkg: shared constants and helpers for the coordinate ASCII frame encoder
// Character codes, coordinate width, divide-by-ten constants and the
// decimal range limit used by the front and back parts.
// -----------------------------------------------------------------------------
package cafe_pkg;

   // field widths
   localparam int COORD_W = 16;
   localparam int BYTE_W  = 8;
   localparam int BCD_W   = 4;

   // default digit count per coordinate
   localparam int DEFAULT_DIGITS = 4;

   // ASCII codes used in the frame
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_Y     = 8'h79;
   localparam logic [BYTE_W-1:0] CHAR_S     = 8'h73;

   // v / 10 == (v * DIV10_MAGIC) >> DIV10_SHIFT, exact for every 16-bit v
   localparam logic [COORD_W-1:0] DIV10_MAGIC = 16'd52429;
   localparam int                 DIV10_SHIFT = 19;

   // 10 ** digits, evaluated at elaboration
   function automatic logic [63:0] pow10(input int digits);
      logic [63:0] lim;
      lim = 64'd1;
      for (int k = 0; k < digits; k++) begin
         lim = lim * 64'd10;
      end
      return lim;
   endfunction

endpackage

>>> hdl/cafe_fifo.sv
// -----------------------------------------------------------------------------
// cafe_fifo: two-entry queue between the converter and the serializer
// Holds converted digit sets so the front can take a new pair while
// the back is still sending an earlier frame.
// -----------------------------------------------------------------------------
module cafe_fifo
   import cafe_pkg::*;
#(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/cafe_front.sv
// -----------------------------------------------------------------------------
// cafe_front: coordinate intake and binary-to-decimal conversion
// Takes one coordinate pair, flags values out of decimal range and peels
// off one decimal digit per cycle for both coordinates in parallel.
// -----------------------------------------------------------------------------
module cafe_front
   import cafe_pkg::*;
#(
   parameter int DIGITS = DEFAULT_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [COORD_W-1:0]            in_x,
   input  logic [COORD_W-1:0]            in_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2*DIGITS*BCD_W:0]       out_data
);

   localparam int          CntW  = $clog2(DIGITS + 1);
   localparam logic [63:0] Limit = pow10(DIGITS);
   localparam int          DigW  = DIGITS * BCD_W;

   logic                 busy_ff, busy_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [COORD_W-1:0]   vx_ff, vx_in, vy_ff, vy_in;
   logic [DigW-1:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic                 wide_ff, wide_in;
   logic                 done, accept, push;
   logic [BCD_W-1:0]     rem_x, rem_y;
   logic [COORD_W-1:0]   quo_x, quo_y;

   // one divide-by-ten step: reciprocal multiply, then remainder
   function automatic logic [COORD_W+BCD_W-1:0] div10(input logic [COORD_W-1:0] v);
      logic [2*COORD_W-1:0] prod;
      logic [COORD_W-1:0]   q;
      logic [COORD_W-1:0]   q10;
      logic [COORD_W-1:0]   r;
      prod = v * DIV10_MAGIC;
      q    = COORD_W'(prod >> DIV10_SHIFT);
      q10  = (q << 3) + (q << 1);
      r    = v - q10;
      return {q, r[BCD_W-1:0]};
   endfunction

   assign {quo_x, rem_x} = div10(vx_ff);
   assign {quo_y, rem_y} = div10(vy_ff);

   assign done      = busy_ff && (cnt_ff == CntW'(DIGITS));
   assign out_valid = done;
   assign push      = done && out_ready;
   assign in_ready  = !busy_ff || push;
   assign accept    = in_valid && in_ready;
   assign out_data  = {wide_ff, dy_ff, dx_ff};

   // conversion sequencing
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      vx_in   = vx_ff;
      vy_in   = vy_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      wide_in = wide_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         vx_in   = in_x;
         vy_in   = in_y;
         wide_in = ({48'd0, in_x} >= Limit) || ({48'd0, in_y} >= Limit);
      end else if (push) begin
         busy_in = 1'b0;
      end else if (busy_ff && !done) begin
         // least significant digit enters first and ends at the top position
         cnt_in = cnt_ff + CntW'(1);
         vx_in  = quo_x;
         vy_in  = quo_y;
         if (DIGITS > 1) begin
            dx_in = {dx_ff[DigW-BCD_W-1:0], rem_x};
            dy_in = {dy_ff[DigW-BCD_W-1:0], rem_y};
         end else begin
            dx_in = DigW'(rem_x);
            dy_in = DigW'(rem_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      wide_ff <= wide_in;
   end

endmodule

>>> hdl/cafe_back.sv
// -----------------------------------------------------------------------------
// cafe_back: frame assembly and byte serializer
// Expands a queued digit set into the ASCII frame and sends it one byte
// per cycle while out_ready is high, through a registered output stage.
// -----------------------------------------------------------------------------
module cafe_back
   import cafe_pkg::*;
#(
   parameter int DIGITS = DEFAULT_DIGITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2*DIGITS*BCD_W:0] in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [BYTE_W-1:0]       out_byte,
   output logic                    out_last,
   output logic                    out_wide
);

   localparam int FrameLen = 2 * DIGITS + 4;
   localparam int PosW     = $clog2(FrameLen);
   localparam int DigW     = DIGITS * BCD_W;

   logic [BYTE_W-1:0] frame_ff [FrameLen];
   logic [BYTE_W-1:0] frame_in [FrameLen];
   logic [BYTE_W-1:0] built    [FrameLen];
   logic [PosW-1:0]   pos_ff, pos_in;
   logic              active_ff, active_in;
   logic              wide_ff, wide_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              owide_ff, owide_in;
   logic              out_free, emit, at_last, pop;
   logic              in_wide;
   logic [DigW-1:0]   in_dx, in_dy;

   assign {in_wide, in_dy, in_dx} = in_data;

   // frame layout: x digits, space, y digits, space, 'y', 's'
   // the most significant digit sits in the lowest nibble of a digit set
   always_comb begin
      for (int k = 0; k < FrameLen; k++) begin
         built[k] = '0;
      end
      if (!in_wide) begin
         for (int k = 0; k < DIGITS; k++) begin
            built[k]          = CHAR_ZERO + {4'd0, in_dx[k*BCD_W +: BCD_W]};
            built[DIGITS+1+k] = CHAR_ZERO + {4'd0, in_dy[k*BCD_W +: BCD_W]};
         end
         built[DIGITS]       = CHAR_SPACE;
         built[2*DIGITS+1]   = CHAR_SPACE;
         built[2*DIGITS+2]   = CHAR_Y;
         built[2*DIGITS+3]   = CHAR_S;
      end
   end

   assign out_free = !valid_ff || out_ready;
   assign emit     = active_ff && out_free;
   assign at_last  = (pos_ff == PosW'(FrameLen - 1));
   assign pop      = in_valid && (!active_ff || (emit && at_last));
   assign in_ready = !active_ff || (emit && at_last);

   // serializer and output stage
   always_comb begin
      frame_in  = frame_ff;
      pos_in    = pos_ff;
      active_in = active_ff;
      wide_in   = wide_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      owide_in  = owide_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = frame_ff[0];
         last_in  = at_last;
         owide_in = wide_ff;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         frame_in  = built;
         pos_in    = '0;
         active_in = 1'b1;
         wide_in   = in_wide;
      end else if (emit) begin
         for (int k = 0; k < FrameLen - 1; k++) begin
            frame_in[k] = frame_ff[k+1];
         end
         frame_in[FrameLen-1] = '0;
         pos_in = pos_ff + PosW'(1);
         if (at_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      wide_ff  <= wide_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      owide_ff <= owide_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_wide  = owide_ff;

endmodule

>>> hdl/coordinate_ascii_frame_encoder.sv
// -----------------------------------------------------------------------------
// coordinate_ascii_frame_encoder: coordinate pair to ASCII serial frame
// Each pair becomes DIGITS zero-padded digits of x, a space, DIGITS digits
// of y, a space, 'y', 's'. Out-of-range pairs give an all-zero frame with
// the error flag set on every byte.
//
//  channel | direction | tdata                              | tlast / tuser
//  --------+-----------+------------------------------------+------------------
//  req_    | in        | [15:0] coord_x, [31:16] coord_y    | -
//  rsp_    | out       | [7:0] frame_byte                   | last_byte/too_wide
//
// The converter peels off the digits of a pair; the serializer then sends
// 2*DIGITS+4 bytes, one per cycle while rsp_tready is high, so the byte
// serializer, not the converter, sets the sustained pair rate.
// Reset is synchronous and clears the control state; no clearing pass.
// Backpressure on rsp_ holds the output register and fills the two-entry
// queue before req_tready drops.
// -----------------------------------------------------------------------------
module coordinate_ascii_frame_encoder
   import cafe_pkg::*;
#(
   parameter int DIGITS = DEFAULT_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] coord_x, [31:16] coord_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] frame_byte
   output logic        rsp_tlast,   // last_byte
   output logic        rsp_tuser    // [0] too_wide
);

   localparam int EntryW = 2 * DIGITS * BCD_W + 1;

   logic              cv_valid, cv_ready;
   logic [EntryW-1:0] cv_data;
   logic              q_valid, q_ready;
   logic [EntryW-1:0] q_data;

   // converter
   cafe_front #(
      .DIGITS (DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[15:0]),
      .in_y      (req_tdata[31:16]),
      .out_valid (cv_valid),
      .out_ready (cv_ready),
      .out_data  (cv_data)
   );

   // queue between converter and serializer
   cafe_fifo #(
      .WIDTH (EntryW)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cv_valid),
      .push_ready (cv_ready),
      .push_data  (cv_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // frame serializer
   cafe_back #(
      .DIGITS (DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_wide  (rsp_tuser)
   );

endmodule
